/* sv/gb_big5_code_map_table_defines.svh */
// Assertion macros for the code map table checker.
// Used by the checker file only; no other dependencies.
`ifndef GB_BIG5_CODE_MAP_TABLE_DEFINES_SVH
`define GB_BIG5_CODE_MAP_TABLE_DEFINES_SVH
// same-cycle implication
`define GBM_ASSERT_NOW(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define GBM_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* sv/gbmap_pkg.sv */
// Shared constants and types for the code map table.
// No dependencies.
package gbmap_pkg;
	localparam int GB_TABLE_DEPTH = 24158;
	localparam int BIG_TABLE_DEPTH = 22719;
	localparam int MAX_CODES = 8;
	localparam int ALT_SLOTS = MAX_CODES - 1;
	localparam int MAIN_DEPTH = GB_TABLE_DEPTH + BIG_TABLE_DEPTH;
	localparam int MA_W = $clog2(MAIN_DEPTH);
	localparam int SLOT_W = $clog2(MAX_CODES);
	localparam int TOT_W = $clog2(MAX_CODES + 1);
	localparam int ALT_DEPTH = MAIN_DEPTH * (2 ** SLOT_W);
	localparam int AA_W = MA_W + SLOT_W;
	localparam int MW_W = SLOT_W + 16;

	localparam logic [15:0] GB_FIRST = 16'hA1A1;
	localparam logic [15:0] GB_LAST = 16'hFEFE;
	localparam logic [15:0] BIG_FIRST = 16'hA140;
	localparam logic [15:0] BIG_LAST = 16'hF9FE;
	localparam logic [15:0] GB_BOX = 16'hA1F5;
	localparam logic [15:0] BIG_BOX = 16'hA1BC;

	localparam logic [1:0] OP_CONVERT = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] REG_DEF_BIG5 = 2'd0;
	localparam logic [1:0] REG_DEF_GB = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	typedef struct packed {
		logic we;
		logic [MA_W-1:0] addr;
		logic [MW_W-1:0] wdata;
	} main_req_t;

	typedef struct packed {
		logic we;
		logic [AA_W-1:0] addr;
		logic [15:0] wdata;
	} alt_req_t;
endpackage

/* sv/gbmap_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module gbmap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

/* sv/gbmap_ctrl.sv */
// Sequencer for the code map table: config registers, lookup, add scan,
// clear sweep and result register. Depends on gbmap_pkg.
module gbmap_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata,
	input logic [2:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic m_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_wdata,
	output gbmap_pkg::main_req_t main_req,
	input logic [gbmap_pkg::MW_W-1:0] main_rdata,
	output gbmap_pkg::alt_req_t alt_req,
	input logic [15:0] alt_rdata
);
	import gbmap_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR = 3'd1;
	localparam logic [2:0] S_MRD = 3'd2;
	localparam logic [2:0] S_MCHK = 3'd3;
	localparam logic [2:0] S_ACHK = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;
	localparam logic [2:0] S_CRD = 3'd6;

	logic [2:0] state_q;
	logic [15:0] def_big_q, def_gb_q;
	logic [3:0] limit_q;
	logic [1:0] op_q;
	logic dir_q;
	logic [15:0] tgt_q;
	logic [MA_W-1:0] entry_q, ptr_q;
	logic clr_reply_q;
	logic [15:0] prim_q;
	logic [SLOT_W-1:0] cnt_q, k_q;
	logic [TOT_W-1:0] total_q;
	logic [15:0] pend_code_q;
	logic [1:0] pend_st_q;
	logic pend_last_q;
	logic ovalid_q;
	logic [15:0] ocode_q;
	logic [1:0] ost_q;
	logic olast_q;

	logic accept;
	logic [1:0] in_op;
	logic in_dir;
	logic [15:0] in_src;
	logic in_ok;
	logic [MA_W-1:0] in_entry;
	logic [15:0] m_prim;
	logic [SLOT_W-1:0] m_cnt;
	logic [TOT_W-1:0] lim, m_total;
	logic [15:0] dflt;
	logic out_free;

	assign in_op = s_tuser[1:0];
	assign in_dir = s_tuser[2];
	assign in_src = s_tdata[15:0];
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !ovalid_q || m_tready;
	assign m_tvalid = ovalid_q;
	assign m_tdata = ocode_q;
	assign m_tuser = ost_q;
	assign m_tlast = olast_q;
	assign m_prim = main_rdata[15:0];
	assign m_cnt = main_rdata[MW_W-1:16];
	assign dflt = dir_q ? def_gb_q : def_big_q;

	always_comb begin
		if (!in_dir) begin
			in_ok = (in_src >= GB_FIRST) && (in_src <= GB_LAST);
			in_entry = MA_W'(in_src - GB_FIRST);
		end else begin
			in_ok = (in_src >= BIG_FIRST) && (in_src <= BIG_LAST);
			in_entry = MA_W'(GB_TABLE_DEPTH) + MA_W'(in_src - BIG_FIRST);
		end
		if (limit_q == 4'd0)
			lim = TOT_W'(1);
		else if (32'(limit_q) > MAX_CODES)
			lim = TOT_W'(MAX_CODES);
		else
			lim = TOT_W'(limit_q);
		m_total = TOT_W'(m_cnt) + TOT_W'(1);
		if (m_total > lim)
			m_total = lim;
	end

	always_comb begin
		main_req.we = 1'b0;
		main_req.addr = entry_q;
		main_req.wdata = '0;
		alt_req.we = 1'b0;
		alt_req.addr = {entry_q, k_q};
		alt_req.wdata = tgt_q;
		case (state_q)
			S_IDLE: main_req.addr = in_entry;
			S_CLR: begin
				main_req.we = 1'b1;
				main_req.addr = ptr_q;
			end
			S_MCHK: begin
				if (op_q == OP_CLEAR)
					main_req.we = 1'b1;
				else if (op_q == OP_ADD && tgt_q != 16'd0 && m_prim == 16'd0) begin
					main_req.we = 1'b1;
					main_req.wdata = {m_cnt, tgt_q};
				end else if (op_q == OP_ADD && tgt_q != 16'd0 && m_prim != tgt_q
					&& m_cnt == '0) begin
					alt_req.we = 1'b1;
					main_req.we = 1'b1;
					main_req.wdata = {SLOT_W'(1), m_prim};
				end
				alt_req.addr = {entry_q, {SLOT_W{1'b0}}};
			end
			S_ACHK: begin
				if (alt_rdata != tgt_q) begin
					if (k_q + SLOT_W'(1) == cnt_q) begin
						if (32'(cnt_q) < ALT_SLOTS) begin
							alt_req.we = 1'b1;
							alt_req.addr = {entry_q, cnt_q};
							main_req.we = 1'b1;
							main_req.wdata = {cnt_q + SLOT_W'(1), prim_q};
						end
					end else begin
						alt_req.addr = {entry_q, k_q + SLOT_W'(1)};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ptr_q <= '0;
			clr_reply_q <= 1'b0;
			ovalid_q <= 1'b0;
			def_big_q <= BIG_BOX;
			def_gb_q <= GB_BOX;
			limit_q <= 4'd8;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEF_BIG5: def_big_q <= cfg_wdata;
					REG_DEF_GB: def_gb_q <= cfg_wdata;
					REG_LIMIT: limit_q <= cfg_wdata[3:0];
					default: ;
				endcase
			end
			if (state_q == S_EMIT && out_free)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= in_op;
						dir_q <= in_dir;
						tgt_q <= s_tdata[31:16];
						entry_q <= in_entry;
						if (in_op == OP_CLEAR_ALL) begin
							ptr_q <= '0;
							clr_reply_q <= 1'b1;
							state_q <= S_CLR;
						end else if (!in_ok) begin
							pend_code_q <= (in_op == OP_CONVERT) ?
								(in_dir ? def_gb_q : def_big_q) : 16'd0;
							pend_st_q <= ST_RANGE;
							pend_last_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MRD;
						end
					end
				end
				S_CLR: begin
					ptr_q <= ptr_q + MA_W'(1);
					if (ptr_q == MA_W'(MAIN_DEPTH - 1)) begin
						pend_code_q <= 16'd0;
						pend_st_q <= ST_OK;
						pend_last_q <= 1'b1;
						state_q <= clr_reply_q ? S_EMIT : S_IDLE;
					end
				end
				S_MRD: state_q <= S_MCHK;
				S_MCHK: begin
					prim_q <= m_prim;
					cnt_q <= m_cnt;
					k_q <= '0;
					total_q <= m_total;
					pend_code_q <= 16'd0;
					pend_st_q <= ST_OK;
					pend_last_q <= 1'b1;
					state_q <= S_EMIT;
					if (op_q == OP_CONVERT) begin
						if (m_prim == 16'd0) begin
							pend_code_q <= dflt;
							pend_st_q <= ST_UNMAPPED;
						end else begin
							pend_code_q <= m_prim;
							pend_last_q <= (m_total == TOT_W'(1));
						end
					end else if (op_q == OP_ADD && tgt_q != 16'd0 && m_prim != 16'd0
						&& m_prim != tgt_q) begin
						if (m_cnt != '0)
							state_q <= S_ACHK;
						else
							state_q <= S_EMIT;
					end
				end
				S_ACHK: begin
					if (alt_rdata == tgt_q) begin
						state_q <= S_EMIT;
					end else if (k_q + SLOT_W'(1) == cnt_q) begin
						if (32'(cnt_q) >= ALT_SLOTS)
							pend_st_q <= ST_FULL;
						state_q <= S_EMIT;
					end else begin
						k_q <= k_q + SLOT_W'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ocode_q <= pend_code_q;
						ost_q <= pend_st_q;
						olast_q <= pend_last_q;
						state_q <= pend_last_q ? S_IDLE : S_CRD;
					end
				end
				S_CRD: begin
					pend_code_q <= alt_rdata;
					pend_st_q <= ST_OK;
					pend_last_q <= (TOT_W'(k_q) + TOT_W'(2) == total_q);
					k_q <= k_q + SLOT_W'(1);
					state_q <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/gb_big5_code_map_table.sv */
// Top level of the GB2312 / Big5 code map table: sequencer plus the
// primary and alternate code RAMs. Depends on gbmap_pkg, gbmap_ctrl, gbmap_ram.
//
// One word is taken at a time. Convert reads the primary RAM, then gives its
// codes one at a time (up to result_limit codes), each further code read from
// the alternate RAM; add scans the stored alternates one by one. The single
// port of each RAM is why these reads go one at a time. After reset, and on
// clear-all, the primary RAM is swept one entry per cycle over all 46877
// entries, with no word accepted.
module gb_big5_code_map_table (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata,   // source_code[15:0], target_code[31:16]
	input logic [2:0] s_tuser,    // opcode[1:0], direction[2]
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata,  // out_code[15:0]
	output logic [1:0] m_tuser,   // status[1:0]
	output logic m_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_wdata
);
	import gbmap_pkg::*;

	main_req_t main_req;
	alt_req_t alt_req;
	logic [MW_W-1:0] main_rdata;
	logic [15:0] alt_rdata;

	gbmap_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.cfg_we, .cfg_index, .cfg_wdata,
		.main_req, .main_rdata, .alt_req, .alt_rdata
	);

	gbmap_ram #(.WIDTH(MW_W), .DEPTH(MAIN_DEPTH)) u_main (
		.clk, .we(main_req.we), .addr(main_req.addr),
		.wdata(main_req.wdata), .rdata(main_rdata)
	);

	gbmap_ram #(.WIDTH(16), .DEPTH(ALT_DEPTH)) u_alt (
		.clk, .we(alt_req.we), .addr(alt_req.addr),
		.wdata(alt_req.wdata), .rdata(alt_rdata)
	);
endmodule

/* sv/gbmap_checker.sv */
// Port-level checks for the code map table, bound to the top level.
// Depends on gb_big5_code_map_table_defines.svh.
`include "gb_big5_code_map_table_defines.svh"
module gbmap_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic m_tlast
);
	`GBM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`GBM_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`GBM_ASSERT_NOW(a_fail_single, m_tvalid && m_tuser != 2'd0, m_tlast)
	`GBM_ASSERT_NOW(a_full_zero, m_tvalid && m_tuser == 2'd3, m_tdata == 16'd0)
endmodule

bind gb_big5_code_map_table gbmap_checker u_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
	.m_tdata, .m_tuser, .m_tlast
);
